### rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared widths, byte patterns and payload types of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

   localparam int BYTE_W       = 8;
   localparam int CODE_POINT_W = 21;
   localparam int EXPECTED_W   = 2;

   localparam logic [CODE_POINT_W-1:0] REPL_CODE_POINT = 21'h00FFFD;

   // Lead byte classes: the byte under the mask must equal the pattern.
   localparam logic [BYTE_W-1:0] LEAD2_MASK    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_PATTERN = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_PATTERN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK    = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_PATTERN = 8'hF0;
   localparam logic [BYTE_W-1:0] CONT_MASK     = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_PATTERN  = 8'h80;
   localparam logic [BYTE_W-1:0] ASCII_LIMIT   = 8'h80;

   localparam logic [EXPECTED_W-1:0] EXPECT_NONE  = 2'd0;
   localparam logic [EXPECTED_W-1:0] EXPECT_ONE   = 2'd1;
   localparam logic [EXPECTED_W-1:0] EXPECT_TWO   = 2'd2;
   localparam logic [EXPECTED_W-1:0] EXPECT_THREE = 2'd3;

   typedef struct packed {
      logic [CODE_POINT_W-1:0] code_point;
      logic                    was_replaced;
      logic                    last_of_run;
   } rsp_payload_type;

   // Outcome of decoding a byte with no sequence open.
   typedef struct packed {
      logic                    has_result;
      rsp_payload_type         result;
      logic [CODE_POINT_W-1:0] partial_code;
      logic [EXPECTED_W-1:0]   bytes_expected;
   } lead_type;

endpackage

`default_nettype wire

### rtl/utf8d_if.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for text bytes in and decoded code points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_req_if;
   import utf8d_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface utf8d_rsp_if;
   import utf8d_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CODE_POINT_W-1:0] code_point;
   logic                    was_replaced;
   logic                    last_of_run;

   modport source (output valid, output code_point, output was_replaced,
                   output last_of_run, input ready);
   modport sink (input valid, input code_point, input was_replaced,
                 input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/utf8d_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder: byte decode
// Holds the open sequence and turns one byte into zero, one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [utf8d_pkg::BYTE_W-1:0]  text_byte,
   output logic [1:0]                    result_count,
   output utf8d_pkg::rsp_payload_type    result0,
   output utf8d_pkg::rsp_payload_type    result1
);
   import utf8d_pkg::*;

   logic [CODE_POINT_W-1:0] partial_ff, partial_in;
   logic [EXPECTED_W-1:0]   expected_ff, expected_in;
   lead_type                lead_now;
   logic [CODE_POINT_W-1:0] shifted;
   rsp_payload_type         repl_last;
   rsp_payload_type         repl_first;

   function automatic lead_type decode_lead(input logic [BYTE_W-1:0] b);
      lead_type l;
      l = '0;
      priority if (b < ASCII_LIMIT) begin
         l.has_result = 1'b1;
         l.result     = '{code_point: {{(CODE_POINT_W-BYTE_W){1'b0}}, b},
                          was_replaced: 1'b0, last_of_run: 1'b1};
      end else if ((b & LEAD2_MASK) == LEAD2_PATTERN) begin
         l.partial_code   = {{(CODE_POINT_W-5){1'b0}}, b[4:0]};
         l.bytes_expected = EXPECT_ONE;
      end else if ((b & LEAD3_MASK) == LEAD3_PATTERN) begin
         l.partial_code   = {{(CODE_POINT_W-4){1'b0}}, b[3:0]};
         l.bytes_expected = EXPECT_TWO;
      end else if ((b & LEAD4_MASK) == LEAD4_PATTERN) begin
         l.partial_code   = {{(CODE_POINT_W-3){1'b0}}, b[2:0]};
         l.bytes_expected = EXPECT_THREE;
      end else begin
         l.has_result = 1'b1;
         l.result     = '{code_point: REPL_CODE_POINT, was_replaced: 1'b1,
                          last_of_run: 1'b1};
      end
      return l;
   endfunction

   assign repl_last  = '{code_point: REPL_CODE_POINT, was_replaced: 1'b1,
                         last_of_run: 1'b1};
   assign repl_first = '{code_point: REPL_CODE_POINT, was_replaced: 1'b1,
                         last_of_run: 1'b0};
   assign shifted    = {partial_ff[CODE_POINT_W-7:0], text_byte[5:0]};

   always_comb begin
      lead_now     = decode_lead(text_byte);
      result_count = 2'd0;
      result0      = lead_now.result;
      result1      = lead_now.result;
      partial_in   = partial_ff;
      expected_in  = expected_ff;
      priority if (text_byte == '0) begin
         // End of text closes any open sequence with a replacement.
         result_count = {1'b0, expected_ff != EXPECT_NONE};
         result0      = repl_last;
         partial_in   = '0;
         expected_in  = EXPECT_NONE;
      end else if (expected_ff == EXPECT_NONE) begin
         result_count = {1'b0, lead_now.has_result};
         partial_in   = lead_now.partial_code;
         expected_in  = lead_now.bytes_expected;
      end else if ((text_byte & CONT_MASK) == CONT_PATTERN) begin
         if (expected_ff == EXPECT_ONE) begin
            result_count = 2'd1;
            result0      = '{code_point: shifted, was_replaced: 1'b0,
                             last_of_run: 1'b1};
            partial_in   = '0;
            expected_in  = EXPECT_NONE;
         end else begin
            partial_in  = shifted;
            expected_in = expected_ff - EXPECT_ONE;
         end
      end else begin
         // A broken sequence is replaced and the byte is decoded again as a lead.
         partial_in  = lead_now.partial_code;
         expected_in = lead_now.bytes_expected;
         if (lead_now.has_result) begin
            result_count = 2'd2;
            result0      = repl_first;
            result1      = lead_now.result;
         end else begin
            result_count = 2'd1;
            result0      = repl_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         expected_ff <= EXPECT_NONE;
      end else if (advance) begin
         partial_ff  <= partial_in;
         expected_ff <= expected_in;
      end
   end

endmodule

`default_nettype wire

### rtl/utf8d_out_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder: result queue
// Two-entry queue that takes up to two results at once and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_out_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_count,
   input  utf8d_pkg::rsp_payload_type push0,
   input  utf8d_pkg::rsp_payload_type push1,
   input  logic                       pop,
   output logic [1:0]                 fill_count,
   output logic                       head_valid,
   output utf8d_pkg::rsp_payload_type head
);
   import utf8d_pkg::*;

   rsp_payload_type entries_ff [2];
   logic            head_ff, head_in;
   logic [1:0]      count_ff, count_in;
   logic            tail;

   assign tail       = head_ff ^ count_ff[0];
   assign head_in    = head_ff ^ pop;
   assign count_in   = count_ff + push_count - {1'b0, pop};
   assign fill_count = count_ff;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entries_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // The caller pushes only what fits in the free entries.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[tail] <= push0;
      end
      if (push_count == 2'd2) begin
         entries_ff[~tail] <= push1;
      end
   end

endmodule

`default_nettype wire

### rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes UTF-8 bytes into code points, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes arrive on the req channel, one per transaction; a zero byte ends
// the text and returns the decoder to its idle state. Decoded code points
// leave on the rsp channel, with was_replaced marking a U+FFFD that stands
// for a malformed sequence and last_of_run marking the final result of a byte.
// A byte taken on the req channel is held in the input register, decoded
// from there and its results are written into the output queue, whose head
// drives the rsp channel. Throughput is one byte per cycle while the queue has
// room for the results. A byte that yields two results while one result is
// still waiting in the two-entry output queue holds until that result leaves,
// and a byte with a result that follows it holds while the full queue drains.
// When the receiver stalls, the queue fills and the input register holds its
// byte, so req ready drops; nothing is lost or repeated.
// Synchronous reset empties the input register and queue and closes any open
// sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
   input  logic  clock,
   input  logic  reset,
   utf8d_req_if.sink   req_bus,
   utf8d_rsp_if.source rsp_bus
);
   import utf8d_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              consume;
   logic              accept;
   logic [1:0]        result_count;
   rsp_payload_type   result0;
   rsp_payload_type   result1;
   logic [1:0]        fill_count;
   logic              head_valid;
   rsp_payload_type   head;
   logic              pop;

   utf8d_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .advance      (consume),
      .text_byte    (in_byte_ff),
      .result_count (result_count),
      .result0      (result0),
      .result1      (result1)
   );

   // Decode only when all results of the byte fit in the queue.
   assign consume = in_valid_ff &&
                    (({1'b0, fill_count} + {1'b0, result_count}) <= 3'd2);
   assign req_bus.ready = !in_valid_ff || consume;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_valid_in   = accept || (in_valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_bus.text_byte;
      end
   end

   utf8d_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (consume ? result_count : 2'd0),
      .push0      (result0),
      .push1      (result1),
      .pop        (pop),
      .fill_count (fill_count),
      .head_valid (head_valid),
      .head       (head)
   );

   assign pop                  = head_valid && rsp_bus.ready;
   assign rsp_bus.valid        = head_valid;
   assign rsp_bus.code_point   = head.code_point;
   assign rsp_bus.was_replaced = head.was_replaced;
   assign rsp_bus.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

### rtl/utf8d_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [utf8d_pkg::CODE_POINT_W-1:0]    rsp_code_point,
   input  logic                                  rsp_was_replaced,
   input  logic                                  rsp_last_of_run
);
   import utf8d_pkg::*;

   // Reset empties the result queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point) &&
      $stable(rsp_was_replaced) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // A replacement always carries U+FFFD.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_replaced |-> rsp_code_point == REPL_CODE_POINT)
      else $error("replacement with wrong code point");

   // Only the replacement for a broken sequence is followed by a second result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_was_replaced)
      else $error("first of two results is not a replacement");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_code_point   (rsp_bus.code_point),
   .rsp_was_replaced (rsp_bus.was_replaced),
   .rsp_last_of_run  (rsp_bus.last_of_run)
);

`default_nettype wire
